@@ rtl/voxel_histogram_density_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the voxel histogram block.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef VOXEL_HISTOGRAM_DENSITY_ASSERT_SVH
`define VOXEL_HISTOGRAM_DENSITY_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define VHD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define VHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vhd_pkg.sv @@
// ----------------------------------------------------------------------------
// vhd_pkg
// Shared types and constants of the voxel histogram block.
// ----------------------------------------------------------------------------
package vhd_pkg;

  localparam int CoordW  = 24;
  localparam int CountW  = 32;
  localparam int DensW   = 26;
  localparam int ProdW   = 48;
  localparam int NumW    = 58;
  localparam int QDepth  = 4;
  localparam int QPtrW   = 2;
  localparam int QCntW   = 3;

  localparam logic [CountW-1:0] COUNT_MAX = '1;
  localparam logic [DensW-1:0]  DENS_MAX  = '1;
  localparam logic [9:0]        SCALE_1000 = 10'd1000;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    REG_MIN_X = 2'd0,
    REG_MIN_Y = 2'd1,
    REG_MIN_Z = 2'd2,
    REG_SCALE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic             f_busy;
    logic [QCntW-1:0] q_count;
    logic             clearing;
  } vhd_status_t;

endpackage

@@ rtl/vhd_ram.sv @@
// ----------------------------------------------------------------------------
// vhd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vhd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/vhd_front.sv @@
// ----------------------------------------------------------------------------
// vhd_front
// Scales the point offsets against the box, then classifies the point and
// forms its voxel address for the queue.
// ----------------------------------------------------------------------------
module vhd_front import vhd_pkg::*; #(
  parameter int BINS = 64,
  parameter int AW   = 18
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [1:0]               action,
  input  logic signed [CoordW-1:0] coord [3],
  input  logic signed [CoordW-1:0] box_min [3],
  input  logic [CoordW-1:0]        bin_scale,
  output logic                     f_valid,
  output logic [AW+2:0]            entry
);

  localparam int IW = $clog2(BINS);

  logic              f_v_r;
  logic [1:0]        act_r;
  logic [2:0]        neg_r;
  logic [ProdW-1:0]  prod_r [3];
  logic [CoordW:0]   off [3];
  logic [CoordW-1:0] bin [3];
  logic [IW-1:0]     idx [3];
  logic [2:0]        ok;
  logic              in_grid;
  logic [AW-1:0]     addr;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      off[a] = {coord[a][CoordW-1], coord[a]} - {box_min[a][CoordW-1], box_min[a]};
      bin[a] = prod_r[a][ProdW-1:CoordW];
      idx[a] = bin[a][IW-1:0];
      ok[a]  = !neg_r[a] && (bin[a] < CoordW'(BINS));
    end
  end

  assign in_grid = &ok;
  assign addr    = in_grid ? AW'((AW'(idx[0]) * AW'(BINS) + AW'(idx[1])) * AW'(BINS)
                             + AW'(idx[2])) : '0;
  assign f_valid = f_v_r;
  assign entry   = {act_r, in_grid, addr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= accept;
    end
    if (accept) begin
      act_r <= action;
      for (int a = 0; a < 3; a++) begin
        neg_r[a]  <= off[a][CoordW];
        prod_r[a] <= off[a][CoordW-1:0] * bin_scale;
      end
    end
  end

endmodule

@@ rtl/vhd_queue.sv @@
// ----------------------------------------------------------------------------
// vhd_queue
// Short FIFO of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module vhd_queue import vhd_pkg::*; #(
  parameter int WIDTH = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic [QCntW-1:0] count
);

  logic [WIDTH-1:0] slot_r [QDepth];
  logic [QPtrW-1:0] wr_r;
  logic [QPtrW-1:0] rd_r;
  logic [QCntW-1:0] cnt_r;

  assign head  = slot_r[rd_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + QCntW'(push) - QCntW'(pop);
    end
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

@@ rtl/vhd_back.sv @@
// ----------------------------------------------------------------------------
// vhd_back
// Executes queued beats against the voxel store: counter updates, density
// division and the clearing sweep.
// ----------------------------------------------------------------------------
module vhd_back import vhd_pkg::*; #(
  parameter int BINS = 64,
  parameter int AW   = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  logic [AW+2:0]     q_head,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_strobe,
  output logic              out_in_box,
  output logic [CountW-1:0] out_bin_count,
  output logic [DensW-1:0]  out_density
);

  localparam int VOXELS = BINS * BINS * BINS;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_MUL, S_DIV
  } state_t;

  state_t            state_r;
  act_t              act_r;
  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     clr_r;
  logic [CountW-1:0] total_r;
  logic [CountW-1:0] count_r;
  logic [NumW-1:0]   num_r;
  logic [NumW-1:0]   quo_r;
  logic [CountW:0]   rem_r;
  logic [5:0]        step_r;
  logic              strobe_r;
  logic              in_box_r;
  logic [CountW-1:0] bin_count_r;
  logic [DensW-1:0]  density_r;

  act_t              h_act;
  logic              h_inside;
  logic [AW-1:0]     h_addr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CountW-1:0] wdata;
  logic [CountW-1:0] rdata;
  logic [CountW-1:0] inc;
  logic [CountW:0]   rem_sh;
  logic              fits;

  assign h_act    = act_t'(q_head[AW+2:AW+1]);
  assign h_inside = q_head[AW];
  assign h_addr   = q_head[AW-1:0];
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign clearing = (state_r == S_CLR);
  assign inc      = (rdata == COUNT_MAX) ? rdata : rdata + 1'b1;
  assign we       = clearing || ((state_r == S_RD) && (act_r == ACT_ADD));
  assign waddr    = clearing ? clr_r : addr_r;
  assign wdata    = clearing ? '0 : inc;
  assign rem_sh   = {rem_r[CountW-1:0], num_r[NumW-1]};
  assign fits     = rem_sh >= {1'b0, total_r};

  assign out_strobe    = strobe_r;
  assign out_in_box    = in_box_r;
  assign out_bin_count = bin_count_r;
  assign out_density   = density_r;

  vhd_ram #(.WIDTH(CountW), .DEPTH(VOXELS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (h_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      total_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          total_r <= '0;
          clr_r   <= clr_r + 1'b1;
          if (clr_r == AW'(VOXELS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            act_r       <= h_act;
            addr_r      <= h_addr;
            in_box_r    <= 1'b0;
            bin_count_r <= '0;
            density_r   <= '0;
            case (h_act)
              ACT_ADD: begin
                if (total_r != COUNT_MAX) begin
                  total_r <= total_r + 1'b1;
                end
                if (h_inside) begin
                  state_r <= S_RD;
                end else begin
                  strobe_r <= 1'b1;
                end
              end
              ACT_QUERY: begin
                if (h_inside) begin
                  state_r <= S_RD;
                end else begin
                  strobe_r <= 1'b1;
                end
              end
              ACT_CLEAR: begin
                strobe_r <= 1'b1;
                clr_r    <= '0;
                state_r  <= S_CLR;
              end
              default: begin
                strobe_r <= 1'b1;
              end
            endcase
          end
        end
        S_RD: begin
          in_box_r <= 1'b1;
          if (act_r == ACT_ADD) begin
            bin_count_r <= inc;
            strobe_r    <= 1'b1;
            state_r     <= S_IDLE;
          end else if (total_r == '0) begin
            bin_count_r <= rdata;
            strobe_r    <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            count_r <= rdata;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          num_r   <= {(NumW-16)'(count_r) * (NumW-16)'(SCALE_1000), 16'h0000};
          quo_r   <= '0;
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= fits ? rem_sh - {1'b0, total_r} : rem_sh;
          quo_r  <= {quo_r[NumW-2:0], fits};
          num_r  <= {num_r[NumW-2:0], 1'b0};
          step_r <= step_r + 1'b1;
          if (step_r == 6'(NumW - 1)) begin
            bin_count_r <= count_r;
            density_r   <= (quo_r[NumW-2:DensW-1] != '0) ? DENS_MAX
                           : {quo_r[DensW-2:0], fits};
            strobe_r    <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/voxel_histogram_density.sv @@
// ----------------------------------------------------------------------------
// voxel_histogram_density
// 3D point histogram over a cubic grid of saturating 32-bit voxel counters.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; every beat gives one
// result, shown for one cycle with out_strobe, and the receiver cannot stall.
// The front registers the scaled offsets of a point, then classifies it and
// hands it to a four-entry queue. The back runs one beat at a time on the
// single port pair of the voxel store: an add reads the voxel, then writes
// it back; a query inside the box runs the bit-serial 58-step divider,
// which it skips while no point has been added. A clear, and reset, start
// a sweep that writes one voxel per cycle over all BINS cubed voxels (262144
// at the default), during which busy stays high; configuration writes are
// taken at any time.
// ----------------------------------------------------------------------------
module voxel_histogram_density import vhd_pkg::*; #(
  parameter int BINS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_action,
  input  logic signed [CoordW-1:0] in_coord_x,
  input  logic signed [CoordW-1:0] in_coord_y,
  input  logic signed [CoordW-1:0] in_coord_z,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CoordW-1:0]        cfg_wdata,
  output logic                     out_strobe,
  output logic                     out_in_box,
  output logic [CountW-1:0]        out_bin_count,
  output logic [DensW-1:0]         out_density
);

  `include "voxel_histogram_density_assert.svh"

  localparam int AW = $clog2(BINS * BINS * BINS);

  logic signed [CoordW-1:0] min_r [3];
  logic [CoordW-1:0]        scale_r;
  logic signed [CoordW-1:0] coord [3];
  logic                     accept;
  logic                     f_valid;
  logic [AW+2:0]            entry;
  logic [AW+2:0]            q_head;
  logic                     q_empty;
  logic                     q_pop;
  logic [QCntW-1:0]         q_count;
  logic                     clearing;
  vhd_status_t              status;

  assign coord[0] = in_coord_x;
  assign coord[1] = in_coord_y;
  assign coord[2] = in_coord_z;
  assign status   = '{f_busy: f_valid, q_count: q_count, clearing: clearing};
  assign busy     = status.clearing || status.f_busy
                    || (status.q_count >= QCntW'(QDepth - 1));
  assign accept   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r[0] <= '0;
      min_r[1] <= '0;
      min_r[2] <= '0;
      scale_r  <= CoordW'(65536);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MIN_X: min_r[0] <= cfg_wdata;
        REG_MIN_Y: min_r[1] <= cfg_wdata;
        REG_MIN_Z: min_r[2] <= cfg_wdata;
        REG_SCALE: scale_r  <= cfg_wdata;
        default:   scale_r  <= scale_r;
      endcase
    end
  end

  vhd_front #(.BINS(BINS), .AW(AW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .coord     (coord),
    .box_min   (min_r),
    .bin_scale (scale_r),
    .f_valid   (f_valid),
    .entry     (entry)
  );

  vhd_queue #(.WIDTH(AW + 3)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data (entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  vhd_back #(.BINS(BINS), .AW(AW)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_strobe    (out_strobe),
    .out_in_box    (out_in_box),
    .out_bin_count (out_bin_count),
    .out_density   (out_density)
  );

  `VHD_ASSERT_SAME(a_outside_zero, out_strobe && !out_in_box,
    out_bin_count == '0 && out_density == '0, "outside result carries data")
  `VHD_ASSERT_SAME(a_dens_range, out_strobe, out_density <= DensW'(65536000),
    "density above full scale")
  `VHD_ASSERT_SAME(a_queue_bound, 1'b1, status.q_count <= QCntW'(QDepth),
    "queue overflow")
  `VHD_ASSERT_NEXT(a_no_pop_clear, status.clearing, !$past(q_pop),
    "queue popped during clearing sweep")

endmodule
